### rtl/cnsp_pkg.sv
// shared types and constants for the column number sum parser
`timescale 1ns / 1ps

package cnsp_pkg;

    // default width of the running total
    localparam int TOTAL_WIDTH = 32;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // field counter limits and reset values
    localparam logic [3:0] FIELD_COUNT_MAX   = 4'd15;
    localparam logic [3:0] FIELD_COUNT_FIRST = 4'd1;
    localparam logic [3:0] FIELD_INDEX_RESET = 4'd3;

    // input op codes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    // parser mode
    typedef enum logic [3:0] {
        MODE_FIELD  = 4'b0001,
        MODE_SPACE  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_TAIL   = 4'b1000
    } t_mode;

    // classified item as it sits in the queue
    typedef struct packed {
        logic       is_end;
        logic       is_space;
        logic       is_newline;
        logic       is_digit;
        logic [3:0] digit;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

### rtl/column_number_sum_parser_core.sv
// top level of the column number sum parser: config register, front, back
`timescale 1ns / 1ps

// an end transfer is stored in the queue, and its result is then registered in the result register
// throughput: one item per cycle while the queue has room; the back end retires one queued item a cycle
// and an end item waits only while an untaken result holds the output register
// a 4-entry queue between classifier and parser absorbs output stalls
// reset: synchronous active low, clears parser, queue and result valid; field index 3

module column_number_sum_parser_core #(
    parameter int TOTAL_WIDTH = cnsp_pkg::TOTAL_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [3:0]             i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_op,
    input  logic [7:0]             i_text_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [TOTAL_WIDTH-1:0] o_listing_total,
    output logic                   o_overflowed
);

    logic [3:0]      r_field_index;
    cnsp_pkg::t_head head;
    logic            pop;

    // field index register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_index <= cnsp_pkg::FIELD_INDEX_RESET;
        end else if (i_cfg_we) begin
            r_field_index <= i_cfg_data;
        end
    end

    // classifier and queue
    cnsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_text_byte (i_text_byte),
        .o_head      (head),
        .i_pop       (pop)
    );

    // parser and accumulator
    cnsp_back #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_field_index   (r_field_index),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_listing_total (o_listing_total),
        .o_overflowed    (o_overflowed)
    );

endmodule

### rtl/cnsp_front.sv
// front end: accepts input transfers, classifies each byte, and queues it
`timescale 1ns / 1ps

module cnsp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [7:0]          i_text_byte,
    output cnsp_pkg::t_head     o_head,
    input  logic                i_pop
);

    localparam int DEPTH  = cnsp_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    cnsp_pkg::t_item r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    cnsp_pkg::t_item class_item;
    logic            push;

    // byte classification
    always_comb begin
        class_item.is_end     = (i_op == cnsp_pkg::OP_END);
        class_item.is_space   = (i_text_byte == cnsp_pkg::CH_SPACE);
        class_item.is_newline = (i_text_byte == cnsp_pkg::CH_NEWLINE);
        class_item.is_digit   = (i_text_byte >= cnsp_pkg::CH_ZERO) &&
                                (i_text_byte <= cnsp_pkg::CH_NINE);
        class_item.digit      = i_text_byte[3:0];
    end

    // handshake and queue head
    assign o_in_ready  = (r_count != CNT_W'(DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_queue[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= class_item;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule

### rtl/cnsp_back.sv
// back end: field skipping, number parsing, saturating sum and result register
`timescale 1ns / 1ps

module cnsp_back #(
    parameter int TOTAL_WIDTH = cnsp_pkg::TOTAL_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [3:0]             i_field_index,
    input  cnsp_pkg::t_head        i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [TOTAL_WIDTH-1:0] o_listing_total,
    output logic                   o_overflowed
);

    localparam int MW = TOTAL_WIDTH + 4;
    localparam int SW = TOTAL_WIDTH + 1;

    cnsp_pkg::t_mode        r_mode, n_mode;
    logic [3:0]             r_field_count, n_field_count;
    logic [TOTAL_WIDTH-1:0] r_pending, n_pending;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;
    logic                   r_ovf, n_ovf;
    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_WIDTH-1:0] r_out_total, n_out_total;
    logic                   r_out_ovf, n_out_ovf;

    cnsp_pkg::t_item        item;
    logic                   take_field, take_number, take_tail;
    logic                   idx_match;
    logic [MW-1:0]          pend_ext, prod;
    logic                   prod_sat;
    logic [SW-1:0]          sum;
    logic [TOTAL_WIDTH-1:0] sum_sat;
    logic                   sum_carry;

    assign item = i_head.item;

    // pop rule: text always moves, an end needs a free result slot
    assign o_pop = i_head.valid && (!item.is_end || !r_out_valid || i_out_ready);

    assign idx_match = (r_field_count == i_field_index);

    // pending * 10 + digit, saturating
    always_comb begin
        pend_ext = MW'(r_pending);
        prod     = (pend_ext << 3) + (pend_ext << 1) + MW'(item.digit);
        prod_sat = |prod[MW-1:TOTAL_WIDTH];
    end

    // total + pending, saturating
    always_comb begin
        sum       = SW'(r_pending) + SW'(r_total);
        sum_carry = sum[TOTAL_WIDTH];
        sum_sat   = sum_carry ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0];
    end

    // which path the head byte takes
    always_comb begin
        take_field  = 1'b0;
        take_number = 1'b0;
        take_tail   = 1'b0;
        case (r_mode)
            cnsp_pkg::MODE_FIELD: begin
                take_field = 1'b1;
            end
            cnsp_pkg::MODE_SPACE: begin
                take_field = !item.is_space;
            end
            cnsp_pkg::MODE_NUMBER: begin
                take_number = 1'b1;
            end
            default: begin
                take_tail = 1'b1;
            end
        endcase
        if (take_field && idx_match) begin
            take_field  = 1'b0;
            take_number = 1'b1;
        end
    end

    // parser state update
    always_comb begin
        n_mode        = r_mode;
        n_field_count = r_field_count;
        n_pending     = r_pending;
        n_total       = r_total;
        n_ovf         = r_ovf;
        n_out_valid   = r_out_valid;
        n_out_total   = r_out_total;
        n_out_ovf     = r_out_ovf;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            if (item.is_end) begin
                // flush pending number, emit, then clear
                n_out_valid = 1'b1;
                if (r_mode == cnsp_pkg::MODE_NUMBER) begin
                    n_out_total = sum_sat;
                    n_out_ovf   = r_ovf || sum_carry;
                end else begin
                    n_out_total = r_total;
                    n_out_ovf   = r_ovf;
                end
                n_mode        = cnsp_pkg::MODE_FIELD;
                n_field_count = cnsp_pkg::FIELD_COUNT_FIRST;
                n_pending     = '0;
                n_total       = '0;
                n_ovf         = 1'b0;
            end else if (take_number) begin
                if (item.is_digit) begin
                    n_mode = cnsp_pkg::MODE_NUMBER;
                    if (prod_sat) begin
                        n_pending = {TOTAL_WIDTH{1'b1}};
                        n_ovf     = 1'b1;
                    end else begin
                        n_pending = prod[TOTAL_WIDTH-1:0];
                    end
                end else begin
                    // number ends: add it and fall into the line tail, or a new line on a newline
                    n_total   = sum_sat;
                    n_ovf     = r_ovf || sum_carry;
                    n_pending = '0;
                    if (item.is_newline) begin
                        n_mode        = cnsp_pkg::MODE_FIELD;
                        n_field_count = cnsp_pkg::FIELD_COUNT_FIRST;
                    end else begin
                        n_mode = cnsp_pkg::MODE_TAIL;
                    end
                end
            end else if (take_field) begin
                if (item.is_space) begin
                    n_mode = cnsp_pkg::MODE_SPACE;
                    if (r_field_count != cnsp_pkg::FIELD_COUNT_MAX) begin
                        n_field_count = r_field_count + 4'd1;
                    end
                end else begin
                    n_mode = cnsp_pkg::MODE_FIELD;
                end
            end else if (take_tail) begin
                if (item.is_newline) begin
                    n_mode        = cnsp_pkg::MODE_FIELD;
                    n_field_count = cnsp_pkg::FIELD_COUNT_FIRST;
                end else begin
                    n_mode = cnsp_pkg::MODE_TAIL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cnsp_pkg::MODE_FIELD;
            r_field_count <= cnsp_pkg::FIELD_COUNT_FIRST;
            r_pending     <= '0;
            r_total       <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_field_count <= n_field_count;
            r_pending     <= n_pending;
            r_total       <= n_total;
            r_ovf         <= n_ovf;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid     = r_out_valid;
    assign o_listing_total = r_out_total;
    assign o_overflowed    = r_out_ovf;

    // checks
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && item.is_end |=> r_out_valid)
        else $error("end transfer did not produce a result");

    a_end_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && item.is_end |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before transfer");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && item.is_end |=> r_total == '0 && !r_ovf &&
            r_field_count == cnsp_pkg::FIELD_COUNT_FIRST)
        else $error("state not cleared after end transfer");

    a_pending_only_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != cnsp_pkg::MODE_NUMBER |-> r_pending == '0)
        else $error("pending number held outside number mode");

endmodule
